### design/zgd_pkg.sv
// ----------------------------------------------------------------------------
// Zeckendorf decomposer package
// Widths, limits, controller state and the command and status records that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package zgd_pkg;

   localparam int VALUE_WIDTH         = 63;
   localparam int INDEX_WIDTH         = 7;
   localparam int FIB_ENTRIES_DEFAULT = 93;
   localparam int MAX_RESULTS         = 46;
   localparam int COUNT_WIDTH         = 6;

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [INDEX_WIDTH-1:0] index_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic flush;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic value_zero;
      logic hit;
      logic rem_zero_next;
      logic at_bottom;
      logic count_full;
      logic pend_valid;
      logic out_free;
   } status_type;

   // Fibonacci number at index k, used only to build start constants.
   function automatic value_type fib_at(input int unsigned k);
      value_type   a;
      value_type   b;
      value_type   t;
      int unsigned i;
      a = '0;
      b = value_type'(1);
      for (i = 0; i < k; i++) begin
         t = a + b;
         a = b;
         b = t;
      end
      return a;
   endfunction

endpackage

`default_nettype wire

### design/zgd_controller.sv
// ----------------------------------------------------------------------------
// Zeckendorf decomposer controller
// Sequences accept, the downward walk and the final flush of each item.
// ----------------------------------------------------------------------------
`default_nettype none

module zgd_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire zgd_pkg::status_type status,
   output zgd_pkg::cmd_type        cmd
);

   zgd_pkg::state_type state_ff;
   zgd_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= zgd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         zgd_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.value_zero ? zgd_pkg::ST_FLUSH : zgd_pkg::ST_WALK;
            end
         end
         zgd_pkg::ST_WALK: begin
            // A hit must push the held term out, which needs a free output.
            cmd.step = !status.hit || !status.pend_valid || status.out_free;
            if (cmd.step && (status.at_bottom ||
                  (status.hit && (status.rem_zero_next || status.count_full)))) begin
               state_in = zgd_pkg::ST_FLUSH;
            end
         end
         zgd_pkg::ST_FLUSH: begin
            cmd.flush = status.out_free;
            if (status.out_free) begin
               state_in = zgd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = zgd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### design/zgd_datapath.sv
// ----------------------------------------------------------------------------
// Zeckendorf decomposer datapath
// Remainder, Fibonacci pair, held term and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module zgd_datapath #(
   parameter int FIB_ENTRIES = zgd_pkg::FIB_ENTRIES_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire zgd_pkg::cmd_type       cmd,
   output zgd_pkg::status_type         status,
   input  wire logic [62:0]            req_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [62:0]                 rsp_term,
   output logic [6:0]                  rsp_term_index,
   output logic                        rsp_last_term,
   output logic                        rsp_empty_res
);

   localparam zgd_pkg::value_type START_CUR  = zgd_pkg::fib_at(FIB_ENTRIES - 1);
   localparam zgd_pkg::value_type START_PREV = zgd_pkg::fib_at(FIB_ENTRIES - 2);
   localparam zgd_pkg::index_type START_IDX  =
      zgd_pkg::index_type'(FIB_ENTRIES - 1);
   localparam zgd_pkg::count_type LAST_COUNT =
      zgd_pkg::count_type'(zgd_pkg::MAX_RESULTS - 1);

   zgd_pkg::value_type rem_ff, rem_in;
   zgd_pkg::value_type cur_ff, cur_in;
   zgd_pkg::value_type prev_ff, prev_in;
   zgd_pkg::index_type idx_ff, idx_in;
   zgd_pkg::count_type count_ff, count_in;

   zgd_pkg::value_type pend_term_ff, pend_term_in;
   zgd_pkg::index_type pend_idx_ff, pend_idx_in;
   logic               pend_empty_ff, pend_empty_in;
   logic               pend_valid_ff, pend_valid_in;

   logic               out_valid_ff, out_valid_in;
   zgd_pkg::value_type out_term_ff, out_term_in;
   zgd_pkg::index_type out_idx_ff, out_idx_in;
   logic               out_last_ff, out_last_in;
   logic               out_empty_ff, out_empty_in;

   logic [zgd_pkg::VALUE_WIDTH:0] diff;
   logic                          hit;
   logic                          out_free;

   assign diff     = {1'b0, rem_ff} - {1'b0, cur_ff};
   assign hit      = !diff[zgd_pkg::VALUE_WIDTH];
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      status               = '0;
      status.value_zero    = (req_value == '0);
      status.hit           = hit;
      status.rem_zero_next = (diff == '0);
      status.at_bottom     = (idx_ff == zgd_pkg::index_type'(1));
      status.count_full    = (count_ff == LAST_COUNT);
      status.pend_valid    = pend_valid_ff;
      status.out_free      = out_free;
   end

   always_comb begin
      rem_in        = rem_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      pend_term_in  = pend_term_ff;
      pend_idx_in   = pend_idx_ff;
      pend_empty_in = pend_empty_ff;
      pend_valid_in = pend_valid_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_term_in   = out_term_ff;
      out_idx_in    = out_idx_ff;
      out_last_in   = out_last_ff;
      out_empty_in  = out_empty_ff;

      if (cmd.load) begin
         rem_in        = req_value;
         cur_in        = START_CUR;
         prev_in       = START_PREV;
         idx_in        = START_IDX;
         count_in      = '0;
         pend_term_in  = '0;
         pend_idx_in   = '0;
         pend_empty_in = (req_value == '0);
         pend_valid_in = (req_value == '0);
      end

      if (cmd.step) begin
         cur_in  = prev_ff;
         prev_in = cur_ff - prev_ff;
         idx_in  = idx_ff - zgd_pkg::index_type'(1);
         if (hit) begin
            rem_in        = diff[zgd_pkg::VALUE_WIDTH-1:0];
            count_in      = count_ff + zgd_pkg::count_type'(1);
            pend_term_in  = cur_ff;
            pend_idx_in   = idx_ff;
            pend_empty_in = 1'b0;
            pend_valid_in = 1'b1;
            if (pend_valid_ff) begin
               out_valid_in = 1'b1;
               out_term_in  = pend_term_ff;
               out_idx_in   = pend_idx_ff;
               out_last_in  = 1'b0;
               out_empty_in = pend_empty_ff;
            end
         end
      end

      if (cmd.flush) begin
         pend_valid_in = 1'b0;
         out_valid_in  = 1'b1;
         out_term_in   = pend_term_ff;
         out_idx_in    = pend_idx_ff;
         out_last_in   = 1'b1;
         out_empty_in  = pend_empty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff        <= '0;
         cur_ff        <= '0;
         prev_ff       <= '0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         rem_ff        <= rem_in;
         cur_ff        <= cur_in;
         prev_ff       <= prev_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      pend_term_ff  <= pend_term_in;
      pend_idx_ff   <= pend_idx_in;
      pend_empty_ff <= pend_empty_in;
      out_term_ff   <= out_term_in;
      out_idx_ff    <= out_idx_in;
      out_last_ff   <= out_last_in;
      out_empty_ff  <= out_empty_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_term       = out_term_ff;
   assign rsp_term_index = out_idx_ff;
   assign rsp_last_term  = out_last_ff;
   assign rsp_empty_res  = out_empty_ff;

endmodule

`default_nettype wire

### design/zeckendorf_greedy_decompose.sv
// Each item is accepted in idle, walked down the Fibonacci indices (at most
// FIB_ENTRIES-1) until the remainder reaches zero, then its final beat is flushed
// to the output register. A new item is taken only once that flush is done. The
// single compare-subtract unit steps the Fibonacci pair downward one index a
// cycle, unless a stalled output holds back a term that must be pushed out.
// Reset (synchronous, active high) returns the controller to idle and clears beats.
// ----------------------------------------------------------------------------
// Zeckendorf greedy decomposer
// Splits a 63-bit value into non-consecutive Fibonacci terms, largest first,
// one result beat per term.
// ----------------------------------------------------------------------------
`default_nettype none

module zeckendorf_greedy_decompose #(
   parameter int FIB_ENTRIES = zgd_pkg::FIB_ENTRIES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [62:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [62:0]      rsp_term,
   output logic [6:0]       rsp_term_index,
   output logic             rsp_last_term,
   output logic             rsp_empty_res
);

   // The controller and the datapath talk only through these two records.
   // The datapath holds the remainder and a consecutive Fibonacci pair, stepped
   // down one index per cycle unless stalled: (fib(i), fib(i-1)) becomes
   // (fib(i-1), fib(i) - fib(i-1)). The start pair is an elaboration constant.
   zgd_pkg::cmd_type    cmd;
   zgd_pkg::status_type status;

   // Each chosen term is parked in a holding register before it is emitted.
   // Only once the next term is found, or the walk ends, is it known whether
   // the parked term is the final one, so its last flag is settled then.
   // A zero input parks the empty result straight away and goes to the flush.
   // The walk also ends once the largest number of results has been found,
   // and terms beyond that are dropped.
   zgd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The output register decouples the result side: the walk carries on while
   // a finished beat waits, and pauses only when a second term must be pushed.
   zgd_datapath #(
      .FIB_ENTRIES (FIB_ENTRIES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_term       (rsp_term),
      .rsp_term_index (rsp_term_index),
      .rsp_last_term  (rsp_last_term),
      .rsp_empty_res  (rsp_empty_res)
   );

   // An empty result is always the only, and therefore last, beat of its item.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |-> (rsp_last_term && rsp_term == '0))
      else $error("empty result without last flag or with a nonzero term");

   // A real term always names an index within the walked table.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_empty_res) |->
         (rsp_term_index != '0 && 32'(rsp_term_index) < FIB_ENTRIES))
      else $error("term index outside the walked range");

   // Once an item is taken, no further item is accepted in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted while a walk is starting");

   // A term of one beat is never zero unless the beat is the empty result.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_empty_res) |-> (rsp_term != '0))
      else $error("zero term in a non-empty result");

endmodule

`default_nettype wire
